>>> hdl/oate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oate_pkg: shared definitions for the overload action trigger evaluator
// constants, field widths, fsm states and divider interface types
// ----------------------------------------------------------------------------
package oate_pkg;

   localparam int TRIGGER_COUNT = 4;
   localparam int FRACTION_BITS = 16;
   localparam int SLOT_COUNT    = 4;
   localparam int SLOT_W        = 2;

   localparam int PRESSURE_W = 17;
   localparam int START_W    = 18;
   localparam int LEVEL_W    = 17;
   localparam int DEN_W      = 18;
   localparam int QUO_W      = FRACTION_BITS;
   localparam int DIV_CNT_W  = $clog2(FRACTION_BITS);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (2 * LEVEL_W + 3);

   // level of a saturated trigger, fits in the level width
   localparam logic [LEVEL_W-1:0] UNIT_LEVEL = LEVEL_W'(64'd1 << FRACTION_BITS);

   localparam logic signed [START_W-1:0] START_RESET = 18'sd131071;
   localparam logic [PRESSURE_W-1:0]     FULL_RESET  = 17'd131071;

   // low bit of a csr index selects the threshold kind
   localparam logic CSR_SEL_START = 1'b0;
   localparam logic CSR_SEL_FULL  = 1'b1;

   localparam logic [SLOT_W-1:0]    SCAN_LAST     = SLOT_W'(TRIGGER_COUNT - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST  = DIV_CNT_W'(FRACTION_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [PRESSURE_W-1:0] dividend;
      logic [DEN_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hdl/oate_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oate_div: bit-serial restoring divider
// forms floor((dividend << FRACTION_BITS) / divisor), one quotient bit a cycle
// ----------------------------------------------------------------------------
module oate_div (
   input  logic                 clock,
   input  logic                 reset,
   input  oate_pkg::div_req_type div_req,
   output oate_pkg::div_rsp_type div_rsp
);
   import oate_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     divisor_ff, divisor_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       trial_sub;
   logic                 take;

   // remainder stays below the divisor, so the doubled value fits one extra bit
   always_comb begin
      trial     = {rem_ff, 1'b0};
      trial_sub = trial - {1'b0, divisor_ff};
      take      = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = DEN_W'(div_req.dividend);
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> hdl/overload_action_trigger_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overload_action_trigger_evaluator: per-trigger level and overall action level
// ramp levels come from a bit-serial divider, the action level from a scan
// ----------------------------------------------------------------------------
// flow: an accepted req word passes setup, the serial divider on a ramp reading
//   (skipped when the level is 0 or full), the trigger scan and emit, which
//   waits for a free result register; a new word is taken only after emit,
//   paced by the one-bit-per-cycle divider and the one-trigger-per-cycle scan
// reset: synchronous, active high; clears levels, action level and fsm, and
//   loads every threshold with 131071
module overload_action_trigger_evaluator (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [oate_pkg::REQ_TDATA_W-1:0]     req_tdata,  // pressure[16:0], zero pad
   input  logic [oate_pkg::REQ_TUSER_W-1:0]     req_tuser,  // trigger_index[1:0]
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // trigger_level[16:0], trigger_full[17], action_level[34:18],
   // action_full[35], action_changed[36], zero pad
   output logic [oate_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // threshold write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [oate_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [oate_pkg::CSR_DATA_W-1:0]      csr_data
);
   import oate_pkg::*;

   // fsm
   state_type state_ff, state_in;

   // thresholds, one pair per trigger slot
   logic signed [START_W-1:0] start_cfg_ff [SLOT_COUNT];
   logic [PRESSURE_W-1:0]     full_cfg_ff  [SLOT_COUNT];

   // stored levels and the running action level
   logic [LEVEL_W-1:0] levels_ff [SLOT_COUNT];
   logic [LEVEL_W-1:0] cur_act_ff, cur_act_in;

   // per-word working registers
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [PRESSURE_W-1:0] pressure_ff, pressure_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [LEVEL_W-1:0]    act_ff, act_in;
   logic                  skip_ff, skip_in;
   logic [SLOT_W-1:0]     scan_ff, scan_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]    out_level_ff, out_level_in;
   logic                  out_tfull_ff, out_tfull_in;
   logic [LEVEL_W-1:0]    out_act_ff, out_act_in;
   logic                  out_afull_ff, out_afull_in;
   logic                  out_changed_ff, out_changed_in;

   // fsm outputs
   logic req_take;
   logic emit_load;
   logic level_write;

   // setup-stage classification of the reading
   logic signed [START_W-1:0] sel_start;
   logic [PRESSURE_W-1:0]     sel_full;
   logic                      idx_valid;
   logic                      at_or_below;
   logic                      at_or_above;
   logic [START_W:0]          num_wide;
   logic [START_W:0]          den_wide;
   logic [LEVEL_W-1:0]        scan_cand;

   div_req_type div_req;
   div_rsp_type div_rsp;

   oate_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ramp bounds: start < p < full, so p - start < full - start < 2^18
   always_comb begin
      sel_start   = start_cfg_ff[idx_ff];
      sel_full    = full_cfg_ff[idx_ff];
      idx_valid   = (int'(idx_ff) < TRIGGER_COUNT);
      at_or_below = ($signed({1'b0, pressure_ff}) <= sel_start);
      at_or_above = (pressure_ff >= sel_full);
      num_wide    = {2'b00, pressure_ff} - {sel_start[START_W-1], sel_start};
      den_wide    = {2'b00, sel_full} - {sel_start[START_W-1], sel_start};
      // the level being updated is not in the store yet
      scan_cand   = (scan_ff == idx_ff) ? level_ff : levels_ff[scan_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (!idx_valid)                      state_in = ST_EMIT;
            else if (at_or_below || at_or_above) state_in = ST_SCAN;
            else                                 state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff == SCAN_LAST) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = num_wide[PRESSURE_W-1:0];
      div_req.divisor  = den_wide[DEN_W-1:0];
      emit_load        = 1'b0;
      level_write      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SETUP:  div_req.start = idx_valid && !at_or_below && !at_or_above;
         ST_DIVIDE: ;
         ST_SCAN:   level_write = (scan_ff == SCAN_LAST);
         ST_EMIT:   emit_load = !rsp_valid_ff || rsp_tready;
         default:   ;
      endcase
   end

   assign req_take = req_tvalid && req_tready;

   // datapath next values
   always_comb begin
      idx_in         = idx_ff;
      pressure_in    = pressure_ff;
      level_in       = level_ff;
      act_in         = act_ff;
      skip_in        = skip_ff;
      scan_in        = scan_ff;
      cur_act_in     = cur_act_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_level_in   = out_level_ff;
      out_tfull_in   = out_tfull_ff;
      out_act_in     = out_act_ff;
      out_afull_in   = out_afull_ff;
      out_changed_in = out_changed_ff;

      if (req_take) begin
         idx_in      = req_tuser[SLOT_W-1:0];
         pressure_in = req_tdata[PRESSURE_W-1:0];
      end

      if (state_ff == ST_SETUP) begin
         skip_in = !idx_valid;
         scan_in = '0;
         // a dropped reading keeps the action level as it is
         act_in  = idx_valid ? '0 : cur_act_ff;
         if (!idx_valid || at_or_below) level_in = '0;
         else if (at_or_above)          level_in = UNIT_LEVEL;
      end

      if (state_ff == ST_DIVIDE && div_rsp.done) begin
         level_in = LEVEL_W'(div_rsp.quotient);
      end

      // running maximum, one trigger per cycle
      if (state_ff == ST_SCAN) begin
         scan_in = scan_ff + 1'b1;
         if (scan_cand > act_ff) act_in = scan_cand;
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (emit_load) begin
         rsp_valid_in   = 1'b1;
         out_level_in   = level_ff;
         out_tfull_in   = !skip_ff && (level_ff == UNIT_LEVEL);
         out_act_in     = act_ff;
         out_afull_in   = (act_ff == UNIT_LEVEL);
         out_changed_in = (act_ff != cur_act_ff);
         cur_act_in     = act_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_act_ff   <= '0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            levels_ff[k]    <= '0;
            start_cfg_ff[k] <= START_RESET;
            full_cfg_ff[k]  <= FULL_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_act_ff   <= cur_act_in;
         if (level_write) levels_ff[idx_ff] <= level_ff;
         // threshold writes, index bit 0 picks start or full
         if (csr_valid && csr_ready) begin
            if (csr_index[0] == CSR_SEL_FULL) begin
               full_cfg_ff[csr_index[CSR_INDEX_W-1:1]] <= csr_data[PRESSURE_W-1:0];
            end else begin
               start_cfg_ff[csr_index[CSR_INDEX_W-1:1]] <= $signed(csr_data[START_W-1:0]);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pressure_ff    <= pressure_in;
      level_ff       <= level_in;
      act_ff         <= act_in;
      skip_ff        <= skip_in;
      scan_ff        <= scan_in;
      out_level_ff   <= out_level_in;
      out_tfull_ff   <= out_tfull_in;
      out_act_ff     <= out_act_in;
      out_afull_ff   <= out_afull_in;
      out_changed_ff <= out_changed_in;
   end

   // threshold writes are taken at once; the writer keeps them clear of words
   // in flight
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_changed_ff, out_afull_ff, out_act_ff,
                        out_tfull_ff, out_level_ff};

   // divider finishes only while the fsm waits for it
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIVIDE)
      else $error("divider done outside divide state");

   // the action level covers the freshly computed trigger level
   a_act_covers_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !skip_ff) |-> act_ff >= level_ff)
      else $error("action level below new trigger level");

   // change flag compares against the action level held before the word
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> out_changed_ff == (out_act_ff != $past(cur_act_ff)))
      else $error("action change flag inconsistent");

   // a dropped reading never reports a change or a full trigger
   a_skip_no_change: assert property (@(posedge clock) disable iff (reset)
      (emit_load && skip_ff) |=> !out_changed_ff && !out_tfull_ff)
      else $error("dropped reading changed the action level");

endmodule

>>> verif/overload_action_trigger_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overload_action_trigger_evaluator_tb: self-checking bench for the evaluator
// drives pressure words and threshold writes, predicts every result word and
// compares it field by field, with random idle bursts on both stream sides
// ----------------------------------------------------------------------------
module overload_action_trigger_evaluator_tb;
   import oate_pkg::*;

   // one predicted result word, unpacked by field
   typedef struct {
      logic [LEVEL_W-1:0] trigger_level;
      logic               trigger_full;
      logic [LEVEL_W-1:0] action_level;
      logic               action_full;
      logic               action_changed;
   } level_report_type;

   // threshold shapes the random phases pick from
   typedef enum int {
      SHAPE_PLAIN,
      SHAPE_RAMP,
      SHAPE_NARROW,
      SHAPE_INVERTED,
      SHAPE_WIDE,
      SHAPE_CLOSED
   } shape_type;

   localparam int PRESSURE_MAX = (1 << PRESSURE_W) - 1;

   // -------------------------------------------------------------------------
   // scoreboard: private copy of thresholds and levels, queue of predictions
   // -------------------------------------------------------------------------
   class level_scoreboard;
      logic signed [START_W-1:0] start_q [SLOT_COUNT];
      logic [PRESSURE_W-1:0]     full_q  [SLOT_COUNT];
      logic [LEVEL_W-1:0]        levels  [SLOT_COUNT];
      logic [LEVEL_W-1:0]        action_now;
      level_report_type          pending_reports[$];
      int                        mismatches;

      function new();
         for (int k = 0; k < SLOT_COUNT; k++) begin
            start_q[k] = START_RESET;
            full_q[k]  = FULL_RESET;
            levels[k]  = '0;
         end
         action_now = '0;
         mismatches = 0;
      endfunction

      // threshold write as seen on the csr channel
      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         int slot;
         slot = int'(index >> 1);
         if (index[0] == CSR_SEL_START)
            start_q[slot] = data[START_W-1:0];
         else
            full_q[slot] = data[PRESSURE_W-1:0];
      endfunction

      // zero at or below start, unit at or above full, linear ramp in between
      function logic [LEVEL_W-1:0] ramp_level(int slot, logic [PRESSURE_W-1:0] p);
         longint s, f, pv, num, den;
         s  = longint'(start_q[slot]);
         f  = longint'({1'b0, full_q[slot]});
         pv = longint'({1'b0, p});
         if (pv <= s)
            return '0;
         if (pv >= f)
            return UNIT_LEVEL;
         num = (pv - s) << FRACTION_BITS;
         den = f - s;
         return LEVEL_W'(num / den);
      endfunction

      // accepted pressure word: update levels and queue the expected result
      function void note_reading(logic [SLOT_W-1:0] idx, logic [PRESSURE_W-1:0] p);
         level_report_type   r;
         logic [LEVEL_W-1:0] prev;
         prev            = action_now;
         r.trigger_level = '0;
         r.trigger_full  = 1'b0;
         if (idx < TRIGGER_COUNT) begin
            r.trigger_level = ramp_level(int'(idx), p);
            levels[idx]     = r.trigger_level;
            action_now      = '0;
            for (int k = 0; k < TRIGGER_COUNT; k++)
               if (levels[k] > action_now)
                  action_now = levels[k];
            r.trigger_full = (r.trigger_level == UNIT_LEVEL);
         end
         r.action_level   = action_now;
         r.action_full    = (action_now == UNIT_LEVEL);
         r.action_changed = (action_now != prev);
         pending_reports.push_back(r);
      endfunction

      function void compare_field(string name, logic [LEVEL_W-1:0] want,
                                  logic [LEVEL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // accepted result word: compare with the oldest prediction
      function void check_report(logic [RSP_TDATA_W-1:0] word);
         level_report_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, word);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("trigger_level", want.trigger_level, word[LEVEL_W-1:0]);
         compare_field("trigger_full", LEVEL_W'(want.trigger_full), LEVEL_W'(word[LEVEL_W]));
         compare_field("action_level", want.action_level, word[2*LEVEL_W:LEVEL_W+1]);
         compare_field("action_full", LEVEL_W'(want.action_full),
                       LEVEL_W'(word[2*LEVEL_W+1]));
         compare_field("action_changed", LEVEL_W'(want.action_changed),
                       LEVEL_W'(word[2*LEVEL_W+2]));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block under test
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // pressure[16:0], zero pad
   logic [REQ_TUSER_W-1:0] req_tuser;   // trigger_index[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // trigger_level[16:0], trigger_full[17], action_level[34:18],
   // action_full[35], action_changed[36], zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   level_scoreboard board = new();

   // chance in percent of an idle burst, per request word or unstalled result check
   int idle_pct = 0;
   int stall_left = 0;

   // tb-side copy of thresholds, used only to aim pressures at the ramp and its edges
   int cur_start [SLOT_COUNT];
   int cur_full  [SLOT_COUNT];

   overload_action_trigger_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // monitor: everything is sampled at the rising edge, result check first so
   // a pop never sees a push from the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_report(rsp_tdata);
         if (req_tvalid && req_tready)
            board.note_reading(req_tuser, req_tdata[PRESSURE_W-1:0]);
         if (csr_valid && csr_ready)
            board.write_register(csr_index, csr_data);
      end
   end

   // result side back-pressure: random stall bursts, none while idle_pct is zero
   always @(negedge clock) begin
      if (reset || idle_pct == 0) begin
         rsp_tready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(99) < idle_pct) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(10, 1) - 1;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // driver tasks, all entered and left at a falling edge
   // -------------------------------------------------------------------------

   // one pressure word, with an optional idle burst in front of it
   task automatic send_reading(input int slot, input int p);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(10, 1);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = SLOT_W'(slot);
      req_tdata  = REQ_TDATA_W'(PRESSURE_W'(p));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      // word taken, do not offer it again
      req_tvalid = 1'b0;
   endtask

   task automatic write_csr(input int index, input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = CSR_INDEX_W'(index);
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // both thresholds of one trigger; a full write may carry a junk top bit
   task automatic configure_trigger(input int slot, input int start, input int full);
      logic junk;
      junk = $urandom_range(1, 0);
      write_csr(2 * slot + int'(CSR_SEL_START), CSR_DATA_W'(start));
      write_csr(2 * slot + int'(CSR_SEL_FULL), {junk, PRESSURE_W'(full)});
      csr_valid = 1'b0;
      cur_start[slot] = start;
      cur_full[slot]  = full;
   endtask

   // wait until every predicted result word has been taken
   task automatic drain();
      while (board.pending_reports.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pick_shape(input int slot);
      shape_type shape;
      int        a, b;
      shape = shape_type'($urandom_range(int'(SHAPE_CLOSED), int'(SHAPE_PLAIN)));
      a = $urandom_range(PRESSURE_MAX, 0);
      b = $urandom_range(PRESSURE_MAX, 0);
      case (shape)
         SHAPE_PLAIN: begin
            configure_trigger(slot, a - 1, a);
         end
         SHAPE_RAMP: begin
            // strictly increasing pair, start may sit at -1
            if (a == b)
               b = (a == PRESSURE_MAX) ? a - 1 : a + 1;
            if (a < b)
               configure_trigger(slot, a - 1, b);
            else
               configure_trigger(slot, b - 1, a);
         end
         SHAPE_NARROW: begin
            a = $urandom_range(PRESSURE_MAX - 12, 0);
            configure_trigger(slot, a, a + $urandom_range(12, 2));
         end
         SHAPE_INVERTED: begin
            // start at or above full, the ramp is never taken
            if (a < b)
               configure_trigger(slot, b, a);
            else
               configure_trigger(slot, a, b);
         end
         SHAPE_WIDE: begin
            configure_trigger(slot, -1, PRESSURE_MAX);
         end
         default: begin
            configure_trigger(slot, PRESSURE_MAX, b);
         end
      endcase
   endtask

   // uniform pressures, plus ones aimed at the ramp, its edges and the range ends
   function automatic int pick_pressure(input int slot);
      int s, f, v;
      s = cur_start[slot];
      f = cur_full[slot];
      case ($urandom_range(9, 0))
         0, 1, 2, 3: v = $urandom_range(PRESSURE_MAX, 0);
         4, 5, 6: begin
            if (f - s > 1)
               v = $urandom_range(f - 1, s + 1);
            else
               v = $urandom_range(PRESSURE_MAX, 0);
         end
         7: v = s + int'($urandom_range(2, 0)) - 1;
         8: v = f + int'($urandom_range(2, 0)) - 1;
         default: v = ($urandom_range(1, 0) != 0) ? PRESSURE_MAX : 0;
      endcase
      if (v < 0)
         v = 0;
      if (v > PRESSURE_MAX)
         v = PRESSURE_MAX;
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         cur_start[k] = int'(START_RESET);
         cur_full[k]  = int'(FULL_RESET);
      end
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset thresholds: every pressure sits at or below start
      send_reading(0, 0);
      send_reading(3, PRESSURE_MAX);
      drain();

      // directed thresholds: wide ramp, plain threshold, narrow ramp, and
      // start above full
      configure_trigger(0, -1, PRESSURE_MAX);
      configure_trigger(1, 65535, 65536);
      configure_trigger(2, 10, 12);
      configure_trigger(3, 100000, 50000);
      send_reading(0, 0);
      send_reading(0, 1);
      send_reading(0, 65536);
      send_reading(0, PRESSURE_MAX - 1);
      send_reading(0, PRESSURE_MAX);
      send_reading(1, 65535);
      send_reading(1, 65536);
      send_reading(2, 10);
      send_reading(2, 11);
      send_reading(2, 12);
      send_reading(3, 75000);
      send_reading(3, 100000);
      send_reading(3, 100001);
      // pull every trigger back down so the action level falls to zero
      send_reading(0, 0);
      send_reading(1, 0);
      send_reading(2, 0);
      send_reading(3, 0);
      drain();

      // random phases, each with fresh thresholds; the last one runs without
      // any idling
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         for (int k = 0; k < TRIGGER_COUNT; k++)
            pick_shape(k);
         case ($urandom_range(2, 0))
            0:       idle_pct = 0;
            1:       idle_pct = 20;
            default: idle_pct = 50;
         endcase
         if (phase == 7)
            idle_pct = 0;
         for (int n = 0; n < 206; n++) begin
            int slot;
            slot = $urandom_range(TRIGGER_COUNT - 1, 0);
            send_reading(slot, pick_pressure(slot));
         end
      end
      req_tvalid = 1'b0;

      // let the last result words arrive, then watch for strays
      drain();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending_reports.size() == 0)
         $display("PASS overload_action_trigger_evaluator");
      else
         $display("FAIL overload_action_trigger_evaluator");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #5000000;
      $display("FAIL overload_action_trigger_evaluator");
      $finish;
   end

endmodule

>>> overload_action_trigger_evaluator.f
hdl/oate_pkg.sv
hdl/oate_div.sv
hdl/overload_action_trigger_evaluator.sv
verif/overload_action_trigger_evaluator_tb.sv
